[rtl/mtfz_pkg.sv]
// shared types and constants for the move-to-front zero-run encoder
`timescale 1ns / 1ps
`default_nettype none

package mtfz_pkg;

    // block length after which a block always ends
    localparam int BLOCK_SIZE = 32768;

    localparam int C_POS_W   = 15;
    localparam int C_LIST_N  = 256;
    localparam int C_RANK_W  = 8;
    localparam int C_RUN_W   = 16;

    // the forced end only exists while the block fits the position counter
    localparam bit                 C_HAS_END = (BLOCK_SIZE <= (1 << C_POS_W));
    localparam logic [C_POS_W-1:0] C_POS_END = C_POS_W'(BLOCK_SIZE - 1);

    localparam logic [7:0]         C_ESCAPE   = 8'd255;
    localparam logic [7:0]         C_ESC_FROM = 8'd253;
    localparam logic [7:0]         C_RANK_OFS = 8'd2;
    localparam logic [C_RUN_W-1:0] C_RUN_MAX  = '1;
    // ceil(2^17 / 3): exact quotient by three for any 16-bit value
    localparam logic [16:0]        C_DIV3_MUL = 17'd43691;
    localparam int                 C_DIV3_SH  = 17;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_SHIFT,
        S_RUN,
        S_SYM,
        S_ESC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic cmp;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/mtfz_cell.sv]
// one list cell: holds a byte, flags a match and takes its neighbour's byte on a move
`timescale 1ns / 1ps
`default_nettype none

module mtfz_cell
    import mtfz_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic [7:0] i_init,
    input  wire t_cell_ctl i_ctl,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_prev,
    input  wire logic      i_blocked,
    output logic [7:0]     o_value,
    output logic           o_hit
);

    logic [7:0] r_val;
    logic       r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= i_init;
        end else if (i_ctl.clear) begin
            r_val <= i_init;
        end else if (i_ctl.shift && !i_blocked) begin
            r_val <= i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= (r_val == i_byte);
        end
    end

    assign o_value = r_val;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

[rtl/mtfz_scan.sv]
// prefix-or over the cell match flags and encoding of the matching cell's rank
`timescale 1ns / 1ps
`default_nettype none

module mtfz_scan
    import mtfz_pkg::*;
(
    input  wire logic [C_LIST_N-1:0] i_hit,
    output logic [C_LIST_N-1:0]      o_blocked,
    output logic [C_RANK_W-1:0]      o_rank
);

    logic [C_RANK_W:0][C_LIST_N-1:0] w_lvl;
    logic [C_LIST_N-1:0]             w_first;

    // log-depth prefix or, one level per doubling of the span
    always_comb begin
        w_lvl[0] = i_hit;
        for (int k = 0; k < C_RANK_W; k++) begin
            for (int i = 0; i < C_LIST_N; i++) begin
                if (i >= (1 << k)) begin
                    w_lvl[k+1][i] = w_lvl[k][i] | w_lvl[k][i - (1 << k)];
                end else begin
                    w_lvl[k+1][i] = w_lvl[k][i];
                end
            end
        end
    end

    // a cell is blocked when a match sits strictly nearer the front
    assign o_blocked = {w_lvl[C_RANK_W][C_LIST_N-2:0], 1'b0};
    assign w_first   = i_hit & ~o_blocked;

    always_comb begin
        o_rank = '0;
        for (int i = 0; i < C_LIST_N; i++) begin
            if (w_first[i]) begin
                o_rank = o_rank | C_RANK_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/mtf_zero_run_encoder_unit.sv]
// top level: cell chain, run counter, digit unit and output register of the encoder
//
// channel  | dir | tdata (low bit first)                  | tuser        | tlast
// s_axis   | in  | suffix_index[14:0], bwt_byte[22:15]    | -            | last_in_block
// m_axis   | out | out_byte[7:0], primary_index[22:8]     | end_of_item  | end_of_block
//
// an item passes accept, then compare and move in the cell chain, then goes straight to close when its byte is
// already at the front and the block goes on; otherwise it passes the run state, which emits the pending run as
// digits from the divide-by-three unit (entered even with no run pending), then, unless the byte was at the front,
// the rank symbol, preceded by an escape byte for high ranks, then close
// reset loads the identity list into the cells in the same cycle, no clearing pass
// a full output register holds the emitting state until m_axis takes the request
`timescale 1ns / 1ps
`default_nettype none

module mtf_zero_run_encoder_unit
    import mtfz_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // suffix_index, bwt_byte, pad
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // out_byte, primary_index, pad
    output logic             o_m_axis_tuser,   // end_of_item
    output logic             o_m_axis_tlast
);

    t_state r_state, n_state;

    logic [7:0]           r_byte;
    logic                 r_last;
    logic                 r_front;
    logic [C_RANK_W-1:0]  r_rank;
    logic [C_RUN_W-1:0]   r_run, n_run;
    logic [C_POS_W-1:0]   r_pos;
    logic [C_POS_W-1:0]   r_primary;

    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_eoi;
    logic                 r_out_eob;
    logic [C_POS_W-1:0]   r_out_primary;

    t_cell_ctl            w_ctl;
    logic [C_LIST_N-1:0]  w_hit;
    logic [C_LIST_N-1:0]  w_blocked;
    logic [7:0]           w_val [C_LIST_N];
    logic [C_RANK_W-1:0]  w_rank;

    logic                 w_accept;
    logic                 w_slot_free;
    logic                 w_emit;
    logic [7:0]           w_emit_byte;
    logic                 w_emit_eoi;
    logic                 w_rank_done;

    logic [C_RUN_W-1:0]   w_rm1;
    logic [32:0]          w_prod;
    logic [C_RUN_W-1:0]   w_q;
    logic [C_RUN_W:0]     w_q3;
    logic [1:0]           w_digit;

    // cell chain, cell 0 takes the incoming byte on a move
    for (genvar g = 0; g < C_LIST_N; g++) begin : g_cell
        mtfz_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_init    (8'(g)),
            .i_ctl     (w_ctl),
            .i_byte    (r_byte),
            .i_prev    ((g == 0) ? r_byte : w_val[(g == 0) ? 0 : g - 1]),
            .i_blocked (w_blocked[g]),
            .o_value   (w_val[g]),
            .o_hit     (w_hit[g])
        );
    end

    mtfz_scan u_scan (
        .i_hit     (w_hit),
        .o_blocked (w_blocked),
        .o_rank    (w_rank)
    );

    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;

    // one bijective base-3 digit per cycle while the output slot is free: (run - 1) mod 3, then (run - 1) div 3
    assign w_rm1   = r_run - C_RUN_W'(1);
    assign w_prod  = 33'(w_rm1) * 33'(C_DIV3_MUL);
    assign w_q     = w_prod[C_DIV3_SH +: C_RUN_W];
    assign w_q3    = {w_q, 1'b0} + {1'b0, w_q};
    assign w_digit = w_rm1[1:0] - w_q3[1:0];

    assign w_rank_done = (r_rank < C_ESC_FROM);

    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        w_ctl       = '0;
        w_emit      = 1'b0;
        w_emit_byte = '0;
        w_emit_eoi  = 1'b0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctl.cmp = 1'b1;
                n_state   = S_SHIFT;
            end
            S_SHIFT: begin
                w_ctl.shift = 1'b1;
                if (w_hit[0]) begin
                    if (r_run != C_RUN_MAX) begin
                        n_run = r_run + C_RUN_W'(1);
                    end
                    n_state = r_last ? S_RUN : S_DONE;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_run == '0) begin
                    n_state = r_front ? S_DONE : S_SYM;
                end else if (w_slot_free) begin
                    w_emit      = 1'b1;
                    w_emit_byte = 8'(w_digit);
                    w_emit_eoi  = (w_q == '0) && r_front;
                    n_run       = w_q;
                    if (w_q == '0) begin
                        n_state = r_front ? S_DONE : S_SYM;
                    end
                end
            end
            S_SYM: begin
                if (w_slot_free) begin
                    w_emit = 1'b1;
                    if (w_rank_done) begin
                        w_emit_byte = r_rank + C_RANK_OFS;
                        w_emit_eoi  = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        w_emit_byte = C_ESCAPE;
                        n_state     = S_ESC;
                    end
                end
            end
            S_ESC: begin
                if (w_slot_free) begin
                    w_emit      = 1'b1;
                    w_emit_byte = r_rank;
                    w_emit_eoi  = 1'b1;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                w_ctl.clear = r_last;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_run     <= '0;
            r_pos     <= '0;
            r_primary <= '0;
        end else begin
            r_state <= n_state;
            r_run   <= n_run;
            if (w_accept && (i_s_axis_tdata[C_POS_W-1:0] == C_POS_W'(1))) begin
                r_primary <= r_pos;
            end
            if (r_state == S_DONE) begin
                if (r_last) begin
                    r_pos     <= '0;
                    r_primary <= '0;
                end else begin
                    r_pos <= r_pos + C_POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_s_axis_tdata[C_POS_W +: 8];
            r_last <= i_s_axis_tlast || (C_HAS_END && (r_pos == C_POS_END));
        end
        if (r_state == S_SHIFT) begin
            r_front <= w_hit[0];
            r_rank  <= w_rank;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte    <= w_emit_byte;
            r_out_eoi     <= w_emit_eoi;
            r_out_eob     <= w_emit_eoi && r_last;
            r_out_primary <= (w_emit_eoi && r_last) ? r_primary : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_primary, r_out_byte};
    assign o_m_axis_tuser  = r_out_eoi;
    assign o_m_axis_tlast  = r_out_eob;

    // the list is a permutation, so exactly one cell matches
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> $onehot(w_hit))
        else $error("cell chain match not unique");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_state == S_RUN)) |-> (w_emit_byte <= 8'd2))
        else $error("run digit out of range");

    a_eob_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser)
        else $error("end of block without end of item");

    a_escape_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ESC) |-> (r_rank >= C_ESC_FROM))
        else $error("escape for a short rank");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && r_last |-> (r_run == '0))
        else $error("run left at end of block");

endmodule

`default_nettype wire
